FILE: sv/ggb_pkg.sv
// ggb_pkg: constants and types of the shortest-cycle search unit
// depends on nothing; used by the interfaces, the top level and the checker
`default_nettype none

package ggb_pkg;

  localparam int MAX_VERTICES = 512;
  localparam int MAX_EDGES    = 16384;

  localparam int VTX_W      = $clog2(MAX_VERTICES);
  localparam int CNT_W      = VTX_W + 1;
  localparam int EDGE_IDX_W = $clog2(MAX_EDGES);
  localparam int EDGE_CNT_W = EDGE_IDX_W + 1;
  localparam int DIST_W     = CNT_W;
  localparam int LEN_W      = DIST_W + 1;
  localparam int OUT_LEN_W  = 10;
  localparam int CFG_W      = 10;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

  localparam logic [DIST_W-1:0] DIST_UNREACHED = '1;
  localparam logic [LEN_W-1:0]  LEN_INF        = '1;
  localparam logic [LEN_W-1:0]  EARLY_STOP     = LEN_W'(3);
  localparam logic [CNT_W-1:0]  N_MAX          = CNT_W'(MAX_VERTICES);
  localparam logic [EDGE_CNT_W-1:0] EDGE_FULL  = EDGE_CNT_W'(MAX_EDGES);

  typedef struct packed {
    logic [DIST_W-1:0] hops;
    logic              par_vld;
    logic [VTX_W-1:0]  par;
  } node_t;

  localparam int NODE_W = $bits(node_t);
  localparam int EDGE_W = 2 * VTX_W;

endpackage

`default_nettype wire

FILE: sv/ggb_if.sv
// ggb_in_if, ggb_out_if: valid/ready channels of the shortest-cycle search unit
// depends on ggb_pkg
`default_nettype none

interface ggb_in_if;
  logic                      valid;
  logic                      ready;
  logic [ggb_pkg::VTX_W-1:0] edge_a;
  logic [ggb_pkg::VTX_W-1:0] edge_b;
  logic                      has_edge;
  logic                      last_item;

  modport source (output valid, edge_a, edge_b, has_edge, last_item, input ready);
  modport sink   (input valid, edge_a, edge_b, has_edge, last_item, output ready);
endinterface

interface ggb_out_if;
  logic                          valid;
  logic                          ready;
  logic [ggb_pkg::OUT_LEN_W-1:0] cycle_length;
  logic                          cycle_found;

  modport source (output valid, cycle_length, cycle_found, input ready);
  modport sink   (input valid, cycle_length, cycle_found, output ready);
endinterface

`default_nettype wire

FILE: sv/graph_girth_bfs_unit.sv
// graph_girth_bfs_unit: edge store plus memory-based breadth-first girth search
// loading: one edge word per cycle; after the last word a breadth-first search runs from
//   each vertex in turn, each step reading the edge ram and, on an edge hit, the node ram,
//   and stops early once a cycle of length 3 is found
// throughput: one graph at a time; input stalls during the search
// reset: synchronous, active low; vertex count 1, empty edge store, no result pending
`default_nettype none

module graph_girth_bfs_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ggb_in_if.sink                             in_ch,
  ggb_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ggb_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [ggb_pkg::PDATA_W-1:0]   pwdata,
  output logic      [ggb_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  typedef enum logic [3:0] {
    ST_LOAD, ST_CLR, ST_DEQ, ST_DEQW, ST_NODEW, ST_EDGE, ST_EDGEW, ST_TOW, ST_FIN, ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [ggb_pkg::CFG_W-1:0]      vcount_r, vcount_nxt;
  logic [ggb_pkg::CNT_W-1:0]      n_r, n_nxt;
  logic [ggb_pkg::EDGE_CNT_W-1:0] total_r, total_nxt;
  logic [ggb_pkg::EDGE_CNT_W-1:0] eidx_r, eidx_nxt;
  logic [ggb_pkg::VTX_W-1:0]      s_r, s_nxt;
  logic [ggb_pkg::VTX_W-1:0]      clr_r, clr_nxt;
  logic [ggb_pkg::CNT_W-1:0]      head_r, head_nxt;
  logic [ggb_pkg::CNT_W-1:0]      tail_r, tail_nxt;
  logic [ggb_pkg::VTX_W-1:0]      u_r, u_nxt;
  logic [ggb_pkg::DIST_W-1:0]     du_r, du_nxt;
  logic                           upv_r, upv_nxt;
  logic [ggb_pkg::VTX_W-1:0]      up_r, up_nxt;
  logic [ggb_pkg::VTX_W-1:0]      to_r, to_nxt;
  logic [ggb_pkg::LEN_W-1:0]      res_r, res_nxt;
  logic [ggb_pkg::LEN_W-1:0]      best_r, best_nxt;
  logic                           ovld_r, ovld_nxt;
  logic [ggb_pkg::OUT_LEN_W-1:0]  olen_r, olen_nxt;
  logic                           ofnd_r, ofnd_nxt;

  logic                            e_we;
  logic [ggb_pkg::EDGE_W-1:0]      e_rdata;
  logic                            q_we;
  logic [ggb_pkg::VTX_W-1:0]       q_waddr, q_wdata, q_rdata;
  logic                            nd_we;
  logic [ggb_pkg::VTX_W-1:0]       nd_waddr, nd_raddr;
  ggb_pkg::node_t                  nd_wdata, nd_rdata;

  logic                            in_acc, cfg_wr;
  logic [ggb_pkg::VTX_W-1:0]       ea, eb, to_c;
  logic                            hit_a, hit, go;
  logic [ggb_pkg::LEN_W-1:0]       cyc_c, res_min, best_min;
  logic [ggb_pkg::CNT_W-1:0]       n_clamp, n_last;

  assign in_ch.ready         = (state_r == ST_LOAD);
  assign in_acc              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = ovld_r;
  assign out_ch.cycle_length = olen_r;
  assign out_ch.cycle_found  = ofnd_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    unique case (paddr[ggb_pkg::PADDR_W-1])
      ggb_pkg::REG_VERTEX_COUNT: prdata = ggb_pkg::PDATA_W'(vcount_r);
      default:                   prdata = '0;
    endcase
  end

  // vertex count clamped to 1..MAX_VERTICES
  always_comb begin
    if (vcount_r == '0) begin
      n_clamp = ggb_pkg::CNT_W'(1);
    end else if (ggb_pkg::CNT_W'(vcount_r) > ggb_pkg::N_MAX) begin
      n_clamp = ggb_pkg::N_MAX;
    end else begin
      n_clamp = ggb_pkg::CNT_W'(vcount_r);
    end
  end
  assign n_last = n_r - ggb_pkg::CNT_W'(1);

  // neighbour of u carried by the current edge word
  assign ea    = e_rdata[ggb_pkg::EDGE_W-1:ggb_pkg::VTX_W];
  assign eb    = e_rdata[ggb_pkg::VTX_W-1:0];
  assign hit_a = (ea == u_r);
  assign to_c  = hit_a ? eb : ea;
  assign hit   = ({1'b0, ea} < n_r) && ({1'b0, eb} < n_r) && (hit_a || (eb == u_r));
  assign go    = hit && !(upv_r && (to_c == up_r));

  assign cyc_c    = ggb_pkg::LEN_W'(nd_rdata.hops) + ggb_pkg::LEN_W'(du_r)
                    + ggb_pkg::LEN_W'(1);
  assign res_min  = (cyc_c < res_r) ? cyc_c : res_r;
  assign best_min = (res_r < best_r) ? res_r : best_r;

  assign e_we = in_acc && in_ch.has_edge && (total_r < ggb_pkg::EDGE_FULL);

  always_comb begin
    q_we     = 1'b0;
    q_waddr  = tail_r[ggb_pkg::VTX_W-1:0];
    q_wdata  = to_r;
    nd_we    = 1'b0;
    nd_waddr = to_r;
    nd_wdata = '{hops: du_r + ggb_pkg::DIST_W'(1), par_vld: 1'b1, par: u_r};
    nd_raddr = (state_r == ST_DEQW) ? q_rdata : to_c;
    if (state_r == ST_CLR) begin
      q_we     = (clr_r == '0);
      q_waddr  = '0;
      q_wdata  = s_r;
      nd_we    = 1'b1;
      nd_waddr = clr_r;
      nd_wdata = '{hops: (clr_r == s_r) ? '0 : ggb_pkg::DIST_UNREACHED,
                   par_vld: 1'b0, par: '0};
    end else if (state_r == ST_TOW && nd_rdata.hops == ggb_pkg::DIST_UNREACHED) begin
      q_we  = 1'b1;
      nd_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    vcount_nxt = vcount_r;
    n_nxt      = n_r;
    total_nxt  = total_r;
    eidx_nxt   = eidx_r;
    s_nxt      = s_r;
    clr_nxt    = clr_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    u_nxt      = u_r;
    du_nxt     = du_r;
    upv_nxt    = upv_r;
    up_nxt     = up_r;
    to_nxt     = to_r;
    res_nxt    = res_r;
    best_nxt   = best_r;
    ovld_nxt   = ovld_r && !out_ch.ready;
    olen_nxt   = olen_r;
    ofnd_nxt   = ofnd_r;

    if (cfg_wr && paddr[ggb_pkg::PADDR_W-1] == ggb_pkg::REG_VERTEX_COUNT) begin
      vcount_nxt = pwdata[ggb_pkg::CFG_W-1:0];
    end

    unique case (state_r)
      ST_LOAD: begin
        if (e_we) begin
          total_nxt = total_r + ggb_pkg::EDGE_CNT_W'(1);
        end
        if (in_acc && in_ch.last_item) begin
          n_nxt     = n_clamp;
          best_nxt  = ggb_pkg::LEN_INF;
          s_nxt     = '0;
          clr_nxt   = '0;
          state_nxt = ST_CLR;
        end
      end
      ST_CLR: begin
        clr_nxt = clr_r + ggb_pkg::VTX_W'(1);
        if ({1'b0, clr_r} == n_last) begin
          head_nxt  = '0;
          tail_nxt  = ggb_pkg::CNT_W'(1);
          res_nxt   = ggb_pkg::LEN_INF;
          state_nxt = ST_DEQ;
        end
      end
      ST_DEQ: begin
        if (head_r == tail_r) begin
          state_nxt = ST_FIN;
        end else begin
          head_nxt  = head_r + ggb_pkg::CNT_W'(1);
          state_nxt = ST_DEQW;
        end
      end
      ST_DEQW: begin
        u_nxt     = q_rdata;
        state_nxt = ST_NODEW;
      end
      ST_NODEW: begin
        du_nxt    = nd_rdata.hops;
        upv_nxt   = nd_rdata.par_vld;
        up_nxt    = nd_rdata.par;
        eidx_nxt  = '0;
        state_nxt = ST_EDGE;
      end
      ST_EDGE: begin
        if (eidx_r == total_r) begin
          state_nxt = ST_DEQ;
        end else begin
          eidx_nxt  = eidx_r + ggb_pkg::EDGE_CNT_W'(1);
          state_nxt = ST_EDGEW;
        end
      end
      ST_EDGEW: begin
        to_nxt    = to_c;
        state_nxt = go ? ST_TOW : ST_EDGE;
      end
      ST_TOW: begin
        state_nxt = ST_EDGE;
        if (nd_rdata.hops == ggb_pkg::DIST_UNREACHED) begin
          tail_nxt = tail_r + ggb_pkg::CNT_W'(1);
        end else begin
          res_nxt = res_min;
          if (res_min == ggb_pkg::EARLY_STOP) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        best_nxt = best_min;
        if (best_min == ggb_pkg::EARLY_STOP || {1'b0, s_r} == n_last) begin
          state_nxt = ST_DONE;
        end else begin
          s_nxt     = s_r + ggb_pkg::VTX_W'(1);
          clr_nxt   = '0;
          state_nxt = ST_CLR;
        end
      end
      ST_DONE: begin
        if (!ovld_r || out_ch.ready) begin
          ovld_nxt  = 1'b1;
          ofnd_nxt  = (best_r != ggb_pkg::LEN_INF);
          olen_nxt  = (best_r != ggb_pkg::LEN_INF) ? best_r[ggb_pkg::OUT_LEN_W-1:0] : '0;
          total_nxt = '0;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      vcount_r <= ggb_pkg::CFG_W'(1);
      total_r  <= '0;
      ovld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      vcount_r <= vcount_nxt;
      total_r  <= total_nxt;
      ovld_r   <= ovld_nxt;
    end
    n_r    <= n_nxt;
    eidx_r <= eidx_nxt;
    s_r    <= s_nxt;
    clr_r  <= clr_nxt;
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    u_r    <= u_nxt;
    du_r   <= du_nxt;
    upv_r  <= upv_nxt;
    up_r   <= up_nxt;
    to_r   <= to_nxt;
    res_r  <= res_nxt;
    best_r <= best_nxt;
    olen_r <= olen_nxt;
    ofnd_r <= ofnd_nxt;
  end

  ggb_ram #(.WIDTH(ggb_pkg::EDGE_W), .DEPTH(ggb_pkg::MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (total_r[ggb_pkg::EDGE_IDX_W-1:0]),
    .wdata ({in_ch.edge_a, in_ch.edge_b}),
    .raddr (eidx_r[ggb_pkg::EDGE_IDX_W-1:0]),
    .rdata (e_rdata)
  );

  ggb_ram #(.WIDTH(ggb_pkg::VTX_W), .DEPTH(ggb_pkg::MAX_VERTICES)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head_r[ggb_pkg::VTX_W-1:0]),
    .rdata (q_rdata)
  );

  ggb_ram #(.WIDTH(ggb_pkg::NODE_W), .DEPTH(ggb_pkg::MAX_VERTICES)) u_node_ram (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_waddr),
    .wdata (nd_wdata),
    .raddr (nd_raddr),
    .rdata (nd_rdata)
  );

endmodule

`default_nettype wire

FILE: sv/ggb_ram.sv
// ggb_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none

module ggb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/ggb_checker.sv
// ggb_checker: port-level assertions for graph_girth_bfs_unit, bound to the top level
// depends on ggb_pkg and graph_girth_bfs_unit
`default_nettype none

module ggb_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          in_last,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [ggb_pkg::OUT_LEN_W-1:0] out_len,
  input wire logic                          out_found
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_len) && $stable(out_found))
    else $error("result word changed while stalled");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_len == '0)
    else $error("length nonzero without a cycle");

  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_len != '0)
    else $error("cycle reported with zero length");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken while search runs");

endmodule

bind graph_girth_bfs_unit ggb_checker u_ggb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_item),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_len   (out_ch.cycle_length),
  .out_found (out_ch.cycle_found)
);

`default_nettype wire
